[rtl/tkl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkl_pkg: shared types and constants for the tilt Kalman level display
// Holds the sequencer state codes, register indexes, reset values and the
// operation codes of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package tkl_pkg;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int STATE_WIDTH_DEF = 48;
	localparam int LED_COUNT_DEF   = 10;
	localparam int DT_BITS         = 16;
	localparam int IDX_W           = 2;
	localparam int CFG_W           = 20;

	localparam logic [IDX_W-1:0] REG_TIME_STEP   = 2'd0;
	localparam logic [IDX_W-1:0] REG_PROC_NOISE  = 2'd1;
	localparam logic [IDX_W-1:0] REG_MEAS_NOISE  = 2'd2;

	localparam logic [15:0] DT_RESET = 16'd655;
	localparam logic [19:0] Q_RESET  = 20'd3277;
	localparam logic [19:0] R_RESET  = 20'd32768;
	localparam logic [15:0] BIAS_RESET_Q16 = 16'd1311;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_DONE
	} state_t;
endpackage

[rtl/tkl_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkl_if: valid/ready channels of the tilt Kalman level display
// Input sample channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface tkl_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] gyro_rate;
	logic signed [15:0] accel_angle;
	modport source (output valid, gyro_rate, accel_angle, input ready);
	modport sink (input valid, gyro_rate, accel_angle, output ready);
endinterface

interface tkl_out_if #(parameter int STATE_WIDTH = 48, parameter int LED_COUNT = 10);
	logic                          valid;
	logic                          ready;
	logic signed [STATE_WIDTH-1:0] angle_estimate;
	logic signed [STATE_WIDTH-1:0] bias_estimate;
	logic [LED_COUNT-1:0]          led_pattern;
	modport source (output valid, angle_estimate, bias_estimate, led_pattern, input ready);
	modport sink (input valid, angle_estimate, bias_estimate, led_pattern, output ready);
endinterface

interface tkl_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [19:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/tkl_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkl_alu: shared saturating fixed-point arithmetic unit
// Add and subtract finish in the cycle after start. Multiply works on
// magnitudes with a 32x32 partial product per cycle and rounds half away from
// zero. Divide is restoring, one quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module tkl_alu #(
	parameter int W = 48,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tkl_pkg::op_t        op,
	input  logic [4:0]          shift,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic                done,
	output logic signed [W-1:0] result
);
	import tkl_pkg::*;

	localparam int MW = 64;
	localparam int DN = W + F;
	localparam int CW = $clog2(DN + 1);

	logic signed [W-1:0] vmax, vmin;
	logic busy_q;
	op_t op_q;
	logic neg_q;
	logic [4:0] sh_q;
	logic [MW-1:0] ua_q, ub_q;
	logic [2*MW-1:0] acc_q;
	logic [2:0] pp_q;
	logic [DN-1:0] num_q;
	logic [W:0] rem_q;
	logic [DN-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic dz_q;
	logic signed [W-1:0] res_q;
	logic done_q;

	logic signed [W:0] sum_w;
	logic [MW-1:0] ma, mb;
	logic [31:0] pa, pb;
	logic [63:0] pp;
	logic [2*MW-1:0] ppsh;
	logic [2*MW-1:0] rnd;
	logic [2*MW-1:0] shd;
	logic [W:0] rem_sh;
	logic [W:0] rem_sub;

	function automatic logic signed [W-1:0] from_mag(input logic neg, input logic [2*MW-1:0] m);
		logic [2*MW-1:0] top;
		top = {{(2*MW-W+1){1'b0}}, {(W-1){1'b1}}};
		if (!neg) from_mag = (m > top) ? {1'b0, {(W-1){1'b1}}} : m[W-1:0];
		else if (m > top) from_mag = {1'b1, {(W-1){1'b0}}};
		else from_mag = -m[W-1:0];
	endfunction

	assign vmax = {1'b0, {(W-1){1'b1}}};
	assign vmin = {1'b1, {(W-1){1'b0}}};
	assign ma = a[W-1] ? MW'(-{{(MW-W){a[W-1]}}, a}) : MW'({{(MW-W){1'b0}}, a});
	assign mb = b[W-1] ? MW'(-{{(MW-W){b[W-1]}}, b}) : MW'({{(MW-W){1'b0}}, b});

	always_comb begin
		if (op == OP_ADD) sum_w = {a[W-1], a} + {b[W-1], b};
		else sum_w = {a[W-1], a} - {b[W-1], b};
		pa = pp_q[1] ? ua_q[63:32] : ua_q[31:0];
		pb = pp_q[0] ? ub_q[63:32] : ub_q[31:0];
		pp = {32'd0, pa} * {32'd0, pb};
		ppsh = {64'd0, pp} << ({5'd0, pp_q[1]} * 32 + {5'd0, pp_q[0]} * 32);
		rnd = acc_q + ({{(2*MW-1){1'b0}}, 1'b1} << (sh_q - 5'd1));
		shd = rnd >> sh_q;
		rem_sh = {rem_q[W-1:0], num_q[DN-1]};
		rem_sub = rem_sh - {1'b0, ub_q[W-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				op_q <= op;
				neg_q <= a[W-1] ^ b[W-1];
				sh_q <= shift;
				ua_q <= ma;
				ub_q <= mb;
				acc_q <= '0;
				pp_q <= 3'd0;
				num_q <= DN'(ma) << F;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= CW'(DN);
				dz_q <= (b == '0);
				if (op == OP_ADD || op == OP_SUB) begin
					if (sum_w > $signed({vmax[W-1], vmax})) res_q <= vmax;
					else if (sum_w < $signed({vmin[W-1], vmin})) res_q <= vmin;
					else res_q <= sum_w[W-1:0];
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (op_q == OP_MUL) begin
					if (pp_q == 3'd4) begin
						res_q <= from_mag(neg_q, (shd >> W != 0) ? '1 : shd);
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						acc_q <= acc_q + ppsh;
						pp_q <= pp_q + 3'd1;
					end
				end else begin
					if (cnt_q == '0) begin
						res_q <= dz_q ? '0 : from_mag(neg_q, {{(2*MW-DN){1'b0}}, quo_q});
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						num_q <= num_q << 1;
						cnt_q <= cnt_q - 1'b1;
						if (!rem_sub[W]) begin
							rem_q <= rem_sub;
							quo_q <= {quo_q[DN-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[DN-2:0], 1'b0};
						end
					end
				end
			end
		end
	end

	assign done = done_q;
	assign result = res_q;
endmodule

[rtl/tilt_kalman_level_display.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_kalman_level_display: two-state Kalman tilt filter with LED level
// A microcoded sequencer steps through predict and correct, issuing each
// operation to one shared saturating add/multiply/divide unit.
// The program holds two divisions, eleven multiplies and sixteen adds or
// subtracts. Input ready whenever the sequencer is idle, so a new sample is
// taken only once the last is finished; a finished result waits only while
// the output register is full.
// Reset: registers return to defaults, angle and covariance clear, bias 0.02.
// ----------------------------------------------------------------------------
module tilt_kalman_level_display #(
	parameter int FRAC_BITS   = tkl_pkg::FRAC_BITS_DEF,
	parameter int STATE_WIDTH = tkl_pkg::STATE_WIDTH_DEF,
	parameter int LED_COUNT   = tkl_pkg::LED_COUNT_DEF
) (
	input logic    clk,
	input logic    arst_n,
	tkl_in_if.sink  in_ch,
	tkl_out_if.source out_ch,
	tkl_cfg_if.sink cfg
);
	import tkl_pkg::*;

	localparam int W = STATE_WIDTH;
	localparam int NSTEP = 29;
	localparam int PW = $clog2(NSTEP + 1);

	// register file slots
	localparam logic [4:0] R_ANG = 5'd0, R_BIAS = 5'd1, R_AA = 5'd2, R_AB = 5'd3;
	localparam logic [4:0] R_BA = 5'd4, R_BB = 5'd5, R_U = 5'd6, R_Z = 5'd7;
	localparam logic [4:0] R_DT = 5'd8, R_Q = 5'd9, R_R = 5'd10, R_ONE = 5'd11;
	localparam logic [4:0] R_APR = 5'd12, R_T = 5'd13, R_P00 = 5'd14, R_P01 = 5'd15;
	localparam logic [4:0] R_P10 = 5'd16, R_P11 = 5'd17, R_DEN = 5'd18, R_K1 = 5'd19;
	localparam logic [4:0] R_K2 = 5'd20, R_Y = 5'd21, R_OMK = 5'd22, R_X = 5'd23;
	localparam int NR = 24;

	typedef struct packed {
		op_t        op;
		logic [4:0] sa;
		logic [4:0] sb;
		logic [4:0] sd;
		logic       fsh;
	} uop_t;

	function automatic uop_t prog(input logic [PW-1:0] pc);
		case (pc)
			0:  prog = '{OP_SUB, R_U,   R_BIAS, R_X,   1'b0};
			1:  prog = '{OP_MUL, R_X,   R_DT,   R_X,   1'b0};
			2:  prog = '{OP_ADD, R_ANG, R_X,    R_APR, 1'b0};
			3:  prog = '{OP_MUL, R_BB,  R_DT,   R_T,   1'b0};
			4:  prog = '{OP_MUL, R_BA,  R_DT,   R_X,   1'b0};
			5:  prog = '{OP_SUB, R_AA,  R_X,    R_P00, 1'b0};
			6:  prog = '{OP_MUL, R_T,   R_DT,   R_X,   1'b0};
			7:  prog = '{OP_ADD, R_P00, R_X,    R_P00, 1'b0};
			8:  prog = '{OP_MUL, R_AB,  R_DT,   R_X,   1'b0};
			9:  prog = '{OP_SUB, R_P00, R_X,    R_P00, 1'b0};
			10: prog = '{OP_ADD, R_P00, R_Q,    R_P00, 1'b0};
			11: prog = '{OP_SUB, R_AB,  R_T,    R_P01, 1'b0};
			12: prog = '{OP_SUB, R_BA,  R_T,    R_P10, 1'b0};
			13: prog = '{OP_ADD, R_BB,  R_Q,    R_P11, 1'b0};
			14: prog = '{OP_ADD, R_P00, R_R,    R_DEN, 1'b0};
			15: prog = '{OP_DIV, R_P00, R_DEN,  R_K1,  1'b0};
			16: prog = '{OP_DIV, R_P10, R_DEN,  R_K2,  1'b0};
			17: prog = '{OP_SUB, R_Z,   R_APR,  R_Y,   1'b0};
			18: prog = '{OP_MUL, R_K1,  R_Y,    R_X,   1'b1};
			19: prog = '{OP_ADD, R_APR, R_X,    R_ANG, 1'b0};
			20: prog = '{OP_MUL, R_K2,  R_Y,    R_X,   1'b1};
			21: prog = '{OP_ADD, R_BIAS, R_X,   R_BIAS, 1'b0};
			22: prog = '{OP_SUB, R_ONE, R_K1,   R_OMK, 1'b0};
			23: prog = '{OP_MUL, R_P00, R_OMK,  R_AA,  1'b1};
			24: prog = '{OP_MUL, R_P01, R_OMK,  R_AB,  1'b1};
			25: prog = '{OP_MUL, R_P00, R_K2,   R_X,   1'b1};
			26: prog = '{OP_SUB, R_P10, R_X,    R_BA,  1'b0};
			27: prog = '{OP_MUL, R_K2,  R_P01,  R_X,   1'b1};
			28: prog = '{OP_SUB, R_P11, R_X,    R_BB,  1'b0};
			default: prog = '{OP_ADD, R_X, R_X, R_X, 1'b0};
		endcase
	endfunction

	state_t state_q, state_d;
	logic [PW-1:0] pc_q;
	logic signed [W-1:0] rf_q [NR];
	logic [15:0] dt_q;
	logic [19:0] q_q, r_q;
	logic out_valid_q;
	logic signed [W-1:0] ang_out_q, bias_out_q;
	logic [LED_COUNT-1:0] led_q;

	uop_t uop;
	logic alu_start, alu_done;
	logic signed [W-1:0] alu_a, alu_b, alu_res;
	logic in_xfer;
	logic out_free;
	logic signed [W-1:0] one_w;
	logic signed [W-1:0] u_w, z_w;

	assign uop = prog(pc_q);
	assign alu_a = rf_q[uop.sa];
	assign alu_b = rf_q[uop.sb];
	assign one_w = W'(1) << FRAC_BITS;
	assign u_w = W'(in_ch.gyro_rate) <<< FRAC_BITS;
	assign z_w = W'(in_ch.accel_angle) <<< FRAC_BITS;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_xfer = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign cfg.ready = 1'b1;

	tkl_alu #(.W(W), .F(FRAC_BITS)) u_alu (
		.clk(clk), .arst_n(arst_n), .start(alu_start), .op(uop.op),
		.shift(uop.fsh ? 5'(FRAC_BITS) : 5'(DT_BITS)),
		.a(alu_a), .b(alu_b), .done(alu_done), .result(alu_res)
	);

	always_comb begin
		state_d = state_q;
		alu_start = 1'b0;
		case (state_q)
			ST_IDLE: if (in_xfer) state_d = ST_ISSUE;
			ST_ISSUE: begin
				alu_start = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: if (alu_done) state_d = (pc_q == PW'(NSTEP - 1)) ? ST_DONE : ST_ISSUE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	function automatic logic [LED_COUNT-1:0] zone(input logic signed [W-1:0] ang);
		logic signed [W:0] d;
		logic signed [W:0] g;
		logic signed [W-1:0] ds;
		g = (W+1)'(1) <<< FRAC_BITS;
		d = {ang[W-1], ang} - 90 * g;
		if (d < -(W+1)'(1) <<< (W-1)) ds = {1'b1, {(W-1){1'b0}}};
		else ds = d[W-1:0];
		d = {ds[W-1], ds};
		if (d >= -45 * g && d <= 45 * g) zone = LED_COUNT'(10'h030);
		else if (d > 45 * g && d <= 90 * g) zone = LED_COUNT'(10'h018);
		else if (d > 90 * g && d <= 135 * g) zone = LED_COUNT'(10'h00C);
		else if (d > 135 * g && d <= 180 * g) zone = LED_COUNT'(10'h006);
		else if (d > 180 * g) zone = LED_COUNT'(10'h001);
		else if (d >= -90 * g) zone = LED_COUNT'(10'h060);
		else if (d >= -135 * g) zone = LED_COUNT'(10'h0C0);
		else if (d >= -180 * g) zone = LED_COUNT'(10'h180);
		else zone = LED_COUNT'(10'h200);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			dt_q <= DT_RESET;
			q_q <= Q_RESET;
			r_q <= R_RESET;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NR; i++) rf_q[i] <= '0;
			rf_q[R_BIAS] <= (W'(BIAS_RESET_Q16) << FRAC_BITS) >> 16;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg.index)
					REG_TIME_STEP:  dt_q <= cfg.data[15:0];
					REG_PROC_NOISE: q_q <= cfg.data;
					REG_MEAS_NOISE: r_q <= cfg.data;
					default: ;
				endcase
			end
			if (in_xfer) begin
				pc_q <= '0;
				rf_q[R_U] <= u_w;
				rf_q[R_Z] <= z_w;
				rf_q[R_DT] <= W'(dt_q);
				rf_q[R_Q] <= W'(q_q);
				rf_q[R_R] <= W'(r_q);
				rf_q[R_ONE] <= one_w;
			end
			if (state_q == ST_WAIT && alu_done) begin
				rf_q[uop.sd] <= alu_res;
				pc_q <= pc_q + 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				ang_out_q <= rf_q[R_ANG];
				bias_out_q <= rf_q[R_BIAS];
				led_q <= zone(rf_q[R_ANG]);
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.angle_estimate = ang_out_q;
	assign out_ch.bias_estimate = bias_out_q;
	assign out_ch.led_pattern = led_q;

	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ch.ready) else $error("input taken while busy");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> out_ch.valid) else $error("result not presented");
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PW'(NSTEP)) else $error("sequencer overran program");
endmodule
